@@ src/assert_macros.svh @@
// Assertion macros shared by the flow time bin accumulator modules.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define FTA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check on every clock edge, reset included
`define FTA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

@@ src/fta_pkg.sv @@
// Package of the flow time bin accumulator: codes, command and status types.
// Used by every module of the block; depends on nothing.
package fta_pkg;

    // Width of the shared divider
    localparam int DIV_W = 64;

    // Request function codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Load mode codes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_MID    = 2'd2;
    localparam logic [1:0] MODE_SPREAD = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_BIN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FIRST_TIME = 2'd1;
    localparam logic [1:0] REG_LOAD_MODE  = 2'd2;

    typedef enum logic [2:0] {
        DIV_BIN_A,
        DIV_BIN_B,
        DIV_SHR_REC,
        DIV_SHR_BYT,
        DIV_SHR_PKT
    } div_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    clr_en;
        logic    capture;
        logic    div_start;
        div_op_t div_op;
        logic    rd_en;
        logic    wr_en;
        logic    walk_step;
        logic    res_load;
    } fta_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic div_done;
        logic oor;
        logic walk_last;
    } fta_sts_t;

endpackage

@@ src/fta_div.sv @@
// Restoring divider for the flow time bin accumulator, one quotient bit a cycle.
// Depends on fta_pkg for the divider width.
module fta_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fta_pkg::DIV_W-1:0]  dividend,
    input  logic [fta_pkg::DIV_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [fta_pkg::DIV_W-1:0]  quotient
);
    import fta_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;

    // One restoring step
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    // Iterate over the dividend bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/fta_datapath.sv @@
// Datapath of the flow time bin accumulator: request registers, bin memories,
// divider, saturating adders and result registers. Depends on fta_pkg, fta_div.
`include "assert_macros.svh"
module fta_datapath #(
    parameter int NUM_BINS  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fta_pkg::fta_cmd_t cmd,
    output fta_pkg::fta_sts_t sts,
    input  logic [31:0]       bin_width,
    input  logic [31:0]       first_time,
    input  logic [1:0]        load_mode,
    input  logic              s_func,
    input  logic [31:0]       s_start_time,
    input  logic [31:0]       s_duration,
    input  logic [31:0]       s_byte_count,
    input  logic [31:0]       s_packet_count,
    input  logic [11:0]       s_bin_select,
    output logic              m_status,
    output logic [63:0]       m_bin_records,
    output logic [63:0]       m_bin_bytes,
    output logic [63:0]       m_bin_packets
);
    import fta_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    // Request registers
    logic        func_reg;
    logic [31:0] st_reg, dur_reg, byt_reg, pkt_reg;
    logic [11:0] sel_reg;

    // Bin walk and shares
    logic [BIN_W-1:0] b1_reg, cur_reg, clr_cnt_reg;
    logic             oor_reg, pre_reg;
    div_op_t          op_reg;
    logic [63:0]      shr_rec_reg, shr_byt_reg, shr_pkt_reg;

    // Memories and read data
    logic [63:0] rec_mem [NUM_BINS];
    logic [63:0] byt_mem [NUM_BINS];
    logic [63:0] pkt_mem [NUM_BINS];
    logic [63:0] rd_rec_reg, rd_byt_reg, rd_pkt_reg;

    // Result registers
    logic        res_status_reg;
    logic [63:0] res_rec_reg, res_byt_reg, res_pkt_reg;

    logic [32:0]      t_a, t_b, t_sel, t_diff;
    logic             before_first;
    logic [31:0]      w_eff;
    logic [BIN_W:0]   n_bins;
    logic [63:0]      div_dividend, div_divisor, div_q;
    logic             div_busy, div_done;
    logic             q_oor, sel_oor;
    logic [BIN_W-1:0] rd_addr;
    logic [64:0]      sum_rec, sum_byt, sum_pkt;
    logic [63:0]      new_rec, new_byt, new_pkt;

    // Time of the bin lookup and its offset from bin zero
    always_comb begin
        unique case (load_mode)
            MODE_END: t_a = {1'b0, st_reg} + {1'b0, dur_reg};
            MODE_MID: t_a = {1'b0, st_reg} + {2'b0, dur_reg[31:1]};
            default:  t_a = {1'b0, st_reg};
        endcase
        t_b          = {1'b0, st_reg} + {1'b0, dur_reg};
        t_sel        = (cmd.div_op == DIV_BIN_B) ? t_b : t_a;
        before_first = t_sel < {1'b0, first_time};
        t_diff       = t_sel - {1'b0, first_time};
        w_eff        = (bin_width == 32'd0) ? 32'd1 : bin_width;
        n_bins       = {1'b0, b1_reg} - {1'b0, cur_reg} + 1'b1;
    end

    // Select divider operands
    always_comb begin
        unique case (cmd.div_op)
            DIV_SHR_REC: begin
                div_dividend = ONE;
                div_divisor  = 64'(n_bins);
            end
            DIV_SHR_BYT: begin
                div_dividend = 64'(byt_reg) << FRAC_BITS;
                div_divisor  = 64'(n_bins);
            end
            DIV_SHR_PKT: begin
                div_dividend = 64'(pkt_reg) << FRAC_BITS;
                div_divisor  = 64'(n_bins);
            end
            default: begin
                div_dividend = 64'(t_diff);
                div_divisor  = 64'(w_eff);
            end
        endcase
    end

    fta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_oor   = div_q >= 64'(NUM_BINS);
    assign sel_oor = 32'(sel_reg) >= 32'(NUM_BINS);

    // Capture the request and collect divider results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oor_reg     <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.clr_en) begin
                clr_cnt_reg <= (clr_cnt_reg == BIN_W'(NUM_BINS - 1)) ? '0
                                                                    : clr_cnt_reg + 1'b1;
            end
            if (cmd.capture) begin
                oor_reg <= 1'b0;
            end else if (div_done && (op_reg == DIV_BIN_A || op_reg == DIV_BIN_B)) begin
                oor_reg <= oor_reg | pre_reg | q_oor;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_func;
            st_reg      <= s_start_time;
            dur_reg     <= s_duration;
            byt_reg     <= s_byte_count;
            pkt_reg     <= s_packet_count;
            sel_reg     <= s_bin_select;
            shr_rec_reg <= ONE;
            shr_byt_reg <= 64'(s_byte_count) << FRAC_BITS;
            shr_pkt_reg <= 64'(s_packet_count) << FRAC_BITS;
        end
        if (cmd.div_start) begin
            op_reg  <= cmd.div_op;
            pre_reg <= before_first;
        end
        if (div_done) begin
            unique case (op_reg)
                DIV_BIN_A: begin
                    cur_reg <= div_q[BIN_W-1:0];
                    b1_reg  <= div_q[BIN_W-1:0];
                end
                DIV_BIN_B:   b1_reg      <= div_q[BIN_W-1:0];
                DIV_SHR_REC: shr_rec_reg <= div_q;
                DIV_SHR_BYT: shr_byt_reg <= div_q;
                default:     shr_pkt_reg <= div_q;
            endcase
        end else if (cmd.walk_step) begin
            cur_reg <= cur_reg + 1'b1;
        end
    end

    // Saturating sums of the bin being updated
    always_comb begin
        sum_rec = {1'b0, rd_rec_reg} + {1'b0, shr_rec_reg};
        sum_byt = {1'b0, rd_byt_reg} + {1'b0, shr_byt_reg};
        sum_pkt = {1'b0, rd_pkt_reg} + {1'b0, shr_pkt_reg};
        new_rec = sum_rec[64] ? '1 : sum_rec[63:0];
        new_byt = sum_byt[64] ? '1 : sum_byt[63:0];
        new_pkt = sum_pkt[64] ? '1 : sum_pkt[63:0];
        rd_addr = (func_reg == FUNC_READ) ? BIN_W'(sel_reg) : cur_reg;
    end

    // Bin memories: clear sweep, update and registered read
    always_ff @(posedge aclk) begin
        if (cmd.clr_en) begin
            rec_mem[clr_cnt_reg] <= '0;
            byt_mem[clr_cnt_reg] <= '0;
            pkt_mem[clr_cnt_reg] <= '0;
        end else if (cmd.wr_en) begin
            rec_mem[cur_reg] <= new_rec;
            byt_mem[cur_reg] <= new_byt;
            pkt_mem[cur_reg] <= new_pkt;
        end
        if (cmd.rd_en) begin
            rd_rec_reg <= rec_mem[rd_addr];
            rd_byt_reg <= byt_mem[rd_addr];
            rd_pkt_reg <= pkt_mem[rd_addr];
        end
    end

    // Load the result
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            if (func_reg == FUNC_READ && !sel_oor) begin
                res_status_reg <= 1'b0;
                res_rec_reg    <= rd_rec_reg;
                res_byt_reg    <= rd_byt_reg;
                res_pkt_reg    <= rd_pkt_reg;
            end else begin
                res_status_reg <= (func_reg == FUNC_READ) ? 1'b1 : oor_reg;
                res_rec_reg    <= '0;
                res_byt_reg    <= '0;
                res_pkt_reg    <= '0;
            end
        end
    end

    assign sts.clr_last  = clr_cnt_reg == BIN_W'(NUM_BINS - 1);
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.oor       = oor_reg;
    assign sts.walk_last = cur_reg == b1_reg;

    assign m_status      = res_status_reg;
    assign m_bin_records = res_rec_reg;
    assign m_bin_bytes   = res_byt_reg;
    assign m_bin_packets = res_pkt_reg;

    `FTA_ASSERT(a_dp_clr_cnt, cmd.clr_en && sts.clr_last |=> clr_cnt_reg == '0, "clear sweep did not wrap")
    `FTA_ASSERT(a_dp_walk_range, cmd.wr_en |-> !oor_reg, "update of an out of range request")
    `FTA_ASSERT(a_dp_done_pulse, div_done |=> !div_done, "divider done held over two cycles")

endmodule

@@ src/fta_ctrl.sv @@
// Controller of the flow time bin accumulator: sequences clearing, divisions,
// bin walks, reads and the result handshake. Depends on fta_pkg.
`include "assert_macros.svh"
module fta_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_func,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        load_mode,
    input  fta_pkg::fta_sts_t sts,
    output fta_pkg::fta_cmd_t cmd
);
    import fta_pkg::*;

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;
    logic    m_valid_reg, m_valid_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            op_reg      <= DIV_BIN_A;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.div_op   = op_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    op_next     = DIV_BIN_A;
                    state_next  = (s_func == FUNC_READ) ? ST_RD_ISSUE : ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    unique case (op_reg)
                        DIV_BIN_A: begin
                            if (load_mode == MODE_SPREAD) begin
                                op_next    = DIV_BIN_B;
                                state_next = ST_DIV_START;
                            end else begin
                                state_next = ST_CHECK;
                            end
                        end
                        DIV_BIN_B:   state_next = ST_CHECK;
                        DIV_SHR_REC: begin
                            op_next    = DIV_SHR_BYT;
                            state_next = ST_DIV_START;
                        end
                        DIV_SHR_BYT: begin
                            op_next    = DIV_SHR_PKT;
                            state_next = ST_DIV_START;
                        end
                        default:     state_next = ST_WALK_RD;
                    endcase
                end
            end
            ST_CHECK: begin
                priority if (sts.oor) begin
                    state_next = ST_RESULT;
                end else if (load_mode == MODE_SPREAD) begin
                    op_next    = DIV_SHR_REC;
                    state_next = ST_DIV_START;
                end else begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_WALK_WR;
            end
            ST_WALK_WR: begin
                cmd.wr_en = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_RD_ISSUE: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    `FTA_ASSERT(a_ctl_wr_clr, !(cmd.wr_en && cmd.clr_en), "update during clear sweep")
    `FTA_ASSERT(a_ctl_div_idle, cmd.div_start |-> !sts.div_busy, "divider started while busy")
    `FTA_ASSERT(a_ctl_res_free, cmd.res_load |-> (!m_valid_reg || m_ready), "result overwritten")
    `FTA_ASSERT_ALWAYS(a_ctl_rst_clear, !aresetn |=> state_reg == ST_CLEAR, "reset left clear")

endmodule

@@ src/flow_time_bin_accumulator_core.sv @@
// Flow time bin accumulator: one request at a time. After reset a clearing
// pass zeroes all bins with s_ready low. A read issues one memory read and
// loads the result. A single-bin add runs one 64-step bin division, then, if
// the bin is in range, a read-modify-write of the bin. A spread add runs two
// 64-step bin divisions (start bin, end bin) and, if both are in range, three
// share divisions on the one shared divider, then a read and a write for each
// covered bin. A result waits in an output register.
module flow_time_bin_accumulator_core #(
    parameter int NUM_BINS  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_start_time,
    input  logic [31:0] s_duration,
    input  logic [31:0] s_byte_count,
    input  logic [31:0] s_packet_count,
    input  logic [11:0] s_bin_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [63:0] m_bin_records,
    output logic [63:0] m_bin_bytes,
    output logic [63:0] m_bin_packets
);
    import fta_pkg::*;

    logic [31:0] bin_width_reg;
    logic [31:0] first_time_reg;
    logic [1:0]  load_mode_reg;
    logic        wr_acc;
    fta_cmd_t    cmd;
    fta_sts_t    sts;

    // Configuration register writes
    assign wr_acc = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_width_reg  <= 32'd300;
            first_time_reg <= 32'd0;
            load_mode_reg  <= MODE_START;
        end else if (wr_acc) begin
            unique case (paddr[3:2])
                REG_BIN_WIDTH:  bin_width_reg  <= pwdata;
                REG_FIRST_TIME: first_time_reg <= pwdata;
                REG_LOAD_MODE:  load_mode_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_BIN_WIDTH:  prdata = bin_width_reg;
            REG_FIRST_TIME: prdata = first_time_reg;
            REG_LOAD_MODE:  prdata = 32'(load_mode_reg);
            default:        prdata = 32'd0;
        endcase
    end

    fta_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_func    (s_func),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .load_mode (load_mode_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    fta_datapath #(
        .NUM_BINS  (NUM_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .bin_width      (bin_width_reg),
        .first_time     (first_time_reg),
        .load_mode      (load_mode_reg),
        .s_func         (s_func),
        .s_start_time   (s_start_time),
        .s_duration     (s_duration),
        .s_byte_count   (s_byte_count),
        .s_packet_count (s_packet_count),
        .s_bin_select   (s_bin_select),
        .m_status       (m_status),
        .m_bin_records  (m_bin_records),
        .m_bin_bytes    (m_bin_bytes),
        .m_bin_packets  (m_bin_packets)
    );

endmodule

@@ sim/flow_time_bin_accumulator_core_tb.sv @@
// Testbench of flow_time_bin_accumulator_core: random and directed flow requests
// checked against an in-bench model of the bin totals. Needs fta_pkg and the core.
`timescale 1ns / 1ps

module flow_time_bin_accumulator_core_tb;
    import fta_pkg::*;

    localparam int NBINS = 4096;
    localparam int FRAC  = 16;

    typedef struct {
        logic        func;
        logic [31:0] st;
        logic [31:0] dur;
        logic [31:0] byt;
        logic [31:0] pkt;
        logic [11:0] sel;
    } flow_req_t;

    typedef struct {
        logic        status;
        logic [63:0] rec;
        logic [63:0] byt;
        logic [63:0] pkt;
    } bin_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [31:0] s_start_time = '0;
    logic [31:0] s_duration = '0;
    logic [31:0] s_byte_count = '0;
    logic [31:0] s_packet_count = '0;
    logic [11:0] s_bin_select = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [63:0] m_bin_records;
    logic [63:0] m_bin_bytes;
    logic [63:0] m_bin_packets;

    flow_time_bin_accumulator_core #(.NUM_BINS(NBINS), .FRAC_BITS(FRAC)) uut (.*);

    // Model state: bin totals and register copies
    logic [63:0] rec_tot [NBINS];
    logic [63:0] byt_tot [NBINS];
    logic [63:0] pkt_tot [NBINS];
    logic [31:0] cfg_width = 32'd300;
    logic [31:0] cfg_first = 32'd0;
    logic [1:0]  cfg_mode  = MODE_START;

    flow_req_t   pending_q[$];
    bin_result_t totals_q[$];
    flow_req_t   cur_req;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    int          n_fail = 0;
    int          n_adds = 0;
    int          n_reads = 0;
    int          n_dropped = 0;
    int          n_checked = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // Map a time to its bin; returns 0 when outside the bin range
    function automatic bit locate_bin(logic [63:0] t, output logic [63:0] b);
        logic [63:0] w;
        w = (cfg_width == 0) ? 64'd1 : {32'd0, cfg_width};
        b = 0;
        if (t < {32'd0, cfg_first}) return 0;
        b = (t - {32'd0, cfg_first}) / w;
        return b < NBINS;
    endfunction

    function automatic void credit_bin(logic [63:0] b, logic [63:0] r, logic [63:0] y,
                                       logic [63:0] p);
        rec_tot[b] = sat_sum(rec_tot[b], r);
        byt_tot[b] = sat_sum(byt_tot[b], y);
        pkt_tot[b] = sat_sum(pkt_tot[b], p);
    endfunction

    // Apply one request to the model totals and return its result
    function automatic bin_result_t account_request(flow_req_t q);
        bin_result_t res;
        logic [63:0] one, vb, vp, b0, b1, n, t;
        bit ok;
        res = '{1'b0, 64'd0, 64'd0, 64'd0};
        one = 64'd1 << FRAC;
        vb  = {32'd0, q.byt} << FRAC;
        vp  = {32'd0, q.pkt} << FRAC;
        if (q.func == FUNC_READ) begin
            n_reads++;
            if (q.sel >= NBINS) begin
                res.status = 1'b1;
            end else begin
                res.rec = rec_tot[q.sel];
                res.byt = byt_tot[q.sel];
                res.pkt = pkt_tot[q.sel];
            end
            return res;
        end
        n_adds++;
        if (cfg_mode == MODE_SPREAD) begin
            ok = locate_bin({32'd0, q.st}, b0);
            ok = ok && locate_bin({32'd0, q.st} + {32'd0, q.dur}, b1);
            if (ok) begin
                n = b1 - b0 + 1;
                for (logic [63:0] i = b0; i <= b1; i++)
                    credit_bin(i, one / n, vb / n, vp / n);
            end
        end else begin
            case (cfg_mode)
                MODE_START: t = {32'd0, q.st};
                MODE_END:   t = {32'd0, q.st} + {32'd0, q.dur};
                default:    t = {32'd0, q.st} + {33'd0, q.dur[31:1]};
            endcase
            ok = locate_bin(t, b0);
            if (ok) credit_bin(b0, one, vb, vp);
        end
        if (!ok) begin
            res.status = 1'b1;
            n_dropped++;
        end
        return res;
    endfunction

    // Driver: present pending requests, predict each one on acceptance
    always @(posedge aclk) begin
        flow_req_t nxt;
        logic v;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            v = s_valid;
            if (s_valid && s_ready) begin
                totals_q.push_back(account_request(cur_req));
                v = 1'b0;
            end
            if (!v && pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                nxt = pending_q.pop_front();
                cur_req = nxt;
                s_func <= nxt.func;
                s_start_time <= nxt.st;
                s_duration <= nxt.dur;
                s_byte_count <= nxt.byt;
                s_packet_count <= nxt.pkt;
                s_bin_select <= nxt.sel;
                v = 1'b1;
            end
            s_valid <= v;
        end
    end

    // Monitor: stall at random, compare each result with the oldest prediction
    always @(posedge aclk) begin
        bin_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (totals_q.size() == 0) begin
                $error("result with no prediction waiting");
                n_fail++;
            end else begin
                e = totals_q.pop_front();
                n_checked++;
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    n_fail++;
                end
                if (m_bin_records !== e.rec) begin
                    $error("bin_records: expected %h, got %h", e.rec, m_bin_records);
                    n_fail++;
                end
                if (m_bin_bytes !== e.byt) begin
                    $error("bin_bytes: expected %h, got %h", e.byt, m_bin_bytes);
                    n_fail++;
                end
                if (m_bin_packets !== e.pkt) begin
                    $error("bin_packets: expected %h, got %h", e.pkt, m_bin_packets);
                    n_fail++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        while (pending_q.size() > 0 || s_valid || totals_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic flow_req_t make_req(logic func, logic [31:0] st, logic [31:0] dur,
                                           logic [31:0] byt, logic [31:0] pkt,
                                           logic [11:0] sel);
        flow_req_t q;
        q = '{func, st, dur, byt, pkt, sel};
        return q;
    endfunction

    // Random request shaped by the current bin layout
    function automatic flow_req_t random_req();
        flow_req_t q;
        logic [63:0] w, span, off, st64, dmax;
        int k;
        k = $urandom_range(99);
        w = (cfg_width == 0) ? 64'd1 : {32'd0, cfg_width};
        q = make_req(FUNC_ADD, 0, 0, $urandom >> $urandom_range(31),
                     $urandom >> $urandom_range(31), 12'($urandom));
        if (k < 15) begin
            q = make_req(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                         12'($urandom));
        end else if (k < 35) begin
            q.func = FUNC_READ;
            q.sel = ($urandom_range(9) < 8) ? 12'($urandom_range(70)) : 12'($urandom);
        end else begin
            span = w * (($urandom_range(9) < 8) ? 64 : 4200);
            off = {$urandom, $urandom} % span;
            st64 = {32'd0, cfg_first} + off;
            q.st = st64[63:32] != 0 ? 32'hFFFF_FFFF : st64[31:0];
            if ($urandom_range(9) == 0 && cfg_first != 0)
                q.st = cfg_first - 1 - 32'($urandom_range(3));
            dmax = w * 3 + 1;
            q.dur = ({$urandom, $urandom} % dmax) > 64'hFFFF_FFFF ? $urandom
                  : 32'({$urandom, $urandom} % dmax);
            if (cfg_mode != MODE_SPREAD && $urandom_range(2) == 0) q.dur = $urandom;
        end
        return q;
    endfunction

    initial begin
        logic [31:0] widths [8] = '{300, 1, 0, 13, 32'hFFFF_FFFF, 5, 1000, 60};
        logic [31:0] firsts [8] = '{0, 1000, 77, 0, 32'hFFFF_FFFF, 32'hFFFF_0000, 123456, 0};
        logic [1:0]  modes  [8] = '{MODE_START, MODE_END, MODE_MID, MODE_SPREAD,
                                    MODE_SPREAD, MODE_SPREAD, MODE_MID, MODE_END};
        int idle_s [4] = '{0, 85, 0, 31};
        int idle_r [4] = '{0, 0, 85, 31};
        foreach (rec_tot[i]) begin
            rec_tot[i] = 0;
            byt_tot[i] = 0;
            pkt_tot[i] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_BIN_WIDTH, widths[ph]);
            write_reg(REG_FIRST_TIME, firsts[ph]);
            write_reg(REG_LOAD_MODE, 32'(modes[ph]));
            cfg_width = widths[ph];
            cfg_first = firsts[ph];
            cfg_mode = modes[ph];
            snd_idle_pct = idle_s[ph % 4];
            rcv_stall_pct = idle_r[ph % 4];
            // Edge requests: extreme counts, time before bin zero, longest flow, reads of the first and last bin
            if (ph < 4) begin
                pending_q.push_back(make_req(FUNC_ADD, cfg_first, 0, 32'hFFFF_FFFF,
                                             32'hFFFF_FFFF, 0));
                pending_q.push_back(make_req(FUNC_ADD, cfg_first - 1, 5, 1, 1, 0));
                pending_q.push_back(make_req(FUNC_ADD, cfg_first, 32'hFFFF_FFFF, 7, 3, 0));
                pending_q.push_back(make_req(FUNC_READ, 0, 0, 0, 0, 0));
                pending_q.push_back(make_req(FUNC_READ, 0, 0, 0, 0, 12'hFFF));
            end
            for (int i = 0; i < 190; i++) begin
                pending_q.push_back(random_req());
                // Hold the sender back until the block has emptied
                if (ph == 2 && i == 95) drain();
            end
            drain();
        end
        $display("covered %0d adds (%0d dropped) and %0d reads over 8 bin layouts",
                 n_adds, n_dropped, n_reads);
        $display("all four load modes used, %0d results checked", n_checked);
        if (n_fail == 0) begin
            $display("flow_time_bin_accumulator_core_tb: clean");
        end else begin
            $display("flow_time_bin_accumulator_core_tb: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #80_000_000;
        $display("flow_time_bin_accumulator_core_tb: errors");
        $finish;
    end

endmodule
